FILE: rtl/joy8dir_pkg.sv
// Shared types, constants and tables for the eight-way joystick direction block.
// No dependencies; used by joystick_eight_way_direction.
package joy8dir_pkg;

  localparam int SAMPLE_BITS         = 10;
  localparam int ANGLE_FRACTION_BITS = 8;

  localparam int CORDIC_STEPS = 16;
  localparam int VEC_SHIFT    = 20;
  localparam int DEG_SHIFT    = 16;

  localparam int CENTRE   = ((1 << SAMPLE_BITS) - 1) / 2;
  localparam int XW       = SAMPLE_BITS + 1;
  localparam int CW       = SAMPLE_BITS + VEC_SHIFT + 3;
  localparam int ZW       = 26;
  localparam int PCT_W    = 7;
  localparam int OFS_W    = 9;
  localparam int CFG_W    = 9;
  localparam int PCT_N    = 1 << PCT_W;

  localparam int FULL     = 360 << ANGLE_FRACTION_BITS;
  localparam int SECT     = 45 << ANGLE_FRACTION_BITS;
  localparam int HALF     = SECT / 2;
  localparam int ANG_W    = $clog2(FULL);
  localparam int SUM_W    = $clog2(FULL + (((1 << OFS_W) - 1) << ANGLE_FRACTION_BITS));
  localparam int Z_FULL   = 360 << DEG_SHIFT;
  localparam int Z_QUART  = 90 << DEG_SHIFT;

  typedef enum logic [0:0] {
    CFG_ANGLE_OFFSET = 1'b0,
    CFG_DEAD_ZONE    = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    DIR_CENTER = 4'd0,
    DIR_N      = 4'd1,
    DIR_NE     = 4'd2,
    DIR_E      = 4'd3,
    DIR_SE     = 4'd4,
    DIR_S      = 4'd5,
    DIR_SW     = 4'd6,
    DIR_W      = 4'd7,
    DIR_NW     = 4'd8
  } dir_t;

  localparam logic [3:0] MASK_N = 4'b0001;
  localparam logic [3:0] MASK_E = 4'b0010;
  localparam logic [3:0] MASK_S = 4'b0100;
  localparam logic [3:0] MASK_W = 4'b1000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_x;
    logic [SAMPLE_BITS-1:0] sample_y;
  } sample_t;

  typedef struct packed {
    logic [3:0] direction;
    logic [3:0] cardinal_mask;
  } result_t;

  typedef struct packed {
    logic in_zone;
    logic zero;
  } flags_t;

  typedef logic [CORDIC_STEPS-1:0][ZW-1:0] atan_table_t;

  localparam atan_table_t ATAN_TABLE = {
    ZW'(115),    ZW'(229),    ZW'(458),    ZW'(917),
    ZW'(1833),   ZW'(3667),   ZW'(7334),   ZW'(14668),
    ZW'(29335),  ZW'(58666),  ZW'(117304), ZW'(234379),
    ZW'(466945), ZW'(919879), ZW'(1740967), ZW'(2949120)
  };

  typedef logic [PCT_N-1:0][SAMPLE_BITS-1:0] dead_table_t;

  function automatic dead_table_t build_dead_table();
    dead_table_t t;
    for (int i = 0; i < PCT_N; i++) begin
      t[i] = SAMPLE_BITS'((CENTRE * i) / 100);
    end
    return t;
  endfunction

  localparam dead_table_t DEAD_TABLE = build_dead_table();

  function automatic logic [3:0] mask_of(dir_t d);
    logic [3:0] m;
    case (d)
      DIR_N:   m = MASK_N;
      DIR_NE:  m = MASK_N | MASK_E;
      DIR_E:   m = MASK_E;
      DIR_SE:  m = MASK_S | MASK_E;
      DIR_S:   m = MASK_S;
      DIR_SW:  m = MASK_S | MASK_W;
      DIR_W:   m = MASK_W;
      DIR_NW:  m = MASK_N | MASK_W;
      default: m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/joystick_eight_way_direction.sv
// Eight-way joystick direction: centring, dead zone, pipelined CORDIC, sector pick.
// Depends on joy8dir_pkg for types, widths, the arctangent and dead zone tables.
//
// Takes one pair of joystick samples per clock while sample_stall is low and
// returns one direction beat per pair, in order. The pipeline registers the
// centring and dead zone test, the quarter-turn step, sixteen CORDIC stages of
// one iteration each, offset add, modulo 360 and sector choice. A stall on the
// result side freezes the whole pipeline and is passed back as sample_stall.
// Configuration writes take effect for beats accepted afterward; write only
// while no beat is in flight.
module joystick_eight_way_direction
  import joy8dir_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  sample_t            sample,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  logic [OFS_W-1:0]       angle_offset;
  logic [SAMPLE_BITS-1:0] dead;
  logic                   advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_offset <= '0;
      dead         <= DEAD_TABLE[10];
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_ANGLE_OFFSET: angle_offset <= cfg_data[OFS_W-1:0];
        CFG_DEAD_ZONE:    dead         <= DEAD_TABLE[cfg_data[PCT_W-1:0]];
        default:          ;
      endcase
    end
  end

  assign advance      = !result_valid || !result_stall;
  assign sample_stall = !advance;

  // entry stage: centre, invert Y, dead zone test
  logic signed [XW-1:0] x_c, y_c, dead_s;
  logic                 in_zone_c;
  logic signed [XW-1:0] ent_x, ent_y;
  flags_t               ent_flags;
  logic                 ent_valid;

  assign x_c       = $signed({1'b0, sample.sample_x}) - $signed(XW'(CENTRE));
  assign y_c       = $signed(XW'(CENTRE)) - $signed({1'b0, sample.sample_y});
  assign dead_s    = $signed({1'b0, dead});
  assign in_zone_c = (x_c > -dead_s) && (x_c < dead_s) && (y_c > -dead_s) && (y_c < dead_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (advance) begin
      ent_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ent_x             <= x_c;
      ent_y             <= y_c;
      ent_flags.in_zone <= in_zone_c;
      ent_flags.zero    <= (x_c == '0) && (y_c == '0);
    end
  end

  // quarter-turn step and CORDIC stages
  logic signed [CW-1:0] cw_a [CORDIC_STEPS+1];
  logic signed [CW-1:0] cw_b [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cw_z [CORDIC_STEPS+1];
  flags_t               cw_flags [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] cw_valid;

  logic signed [CW-1:0] na, nb;

  assign na = CW'(ent_y) <<< VEC_SHIFT;
  assign nb = CW'(ent_x) <<< VEC_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      cw_valid <= '0;
    end else if (advance) begin
      cw_valid <= {cw_valid[CORDIC_STEPS-1:0], ent_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cw_flags[0] <= ent_flags;
      if (na < 0) begin
        if (nb >= 0) begin
          cw_a[0] <= nb;
          cw_b[0] <= -na;
          cw_z[0] <= ZW'(Z_QUART);
        end else begin
          cw_a[0] <= -nb;
          cw_b[0] <= na;
          cw_z[0] <= -$signed(ZW'(Z_QUART));
        end
      end else begin
        cw_a[0] <= na;
        cw_b[0] <= nb;
        cw_z[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CW-1:0] sa, sb;
    logic signed [ZW-1:0] at;

    assign sa = cw_a[i] >>> i;
    assign sb = cw_b[i] >>> i;
    assign at = $signed(ATAN_TABLE[i]);

    always_ff @(posedge clk) begin
      if (advance) begin
        cw_flags[i+1] <= cw_flags[i];
        if (cw_b[i] >= 0) begin
          cw_a[i+1] <= cw_a[i] + sb;
          cw_b[i+1] <= cw_b[i] - sa;
          cw_z[i+1] <= cw_z[i] + at;
        end else begin
          cw_a[i+1] <= cw_a[i] - sb;
          cw_b[i+1] <= cw_b[i] + sa;
          cw_z[i+1] <= cw_z[i] - at;
        end
      end
    end
  end

  // wrap to positive, truncate, add offset
  logic signed [ZW-1:0] z_fin, z_pos;
  logic [ANG_W-1:0]     ang_raw;
  logic [SUM_W-1:0]     sum;
  flags_t               sum_flags;
  logic                 sum_valid;

  assign z_fin   = cw_z[CORDIC_STEPS];
  assign z_pos   = cw_flags[CORDIC_STEPS].zero ? '0 :
                   (z_fin < 0) ? z_fin + $signed(ZW'(Z_FULL)) : z_fin;
  assign ang_raw = z_pos[DEG_SHIFT-ANGLE_FRACTION_BITS +: ANG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (advance) begin
      sum_valid <= cw_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum_flags <= cw_flags[CORDIC_STEPS];
      sum       <= SUM_W'(ang_raw) + SUM_W'({angle_offset, ANGLE_FRACTION_BITS'(0)});
    end
  end

  // modulo 360 degrees
  logic [ANG_W-1:0] ang;
  flags_t           ang_flags;
  logic             ang_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_valid <= 1'b0;
    end else if (advance) begin
      ang_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ang_flags <= sum_flags;
      if (sum >= SUM_W'(2 * FULL)) begin
        ang <= ANG_W'(sum - SUM_W'(2 * FULL));
      end else if (sum >= SUM_W'(FULL)) begin
        ang <= ANG_W'(sum - SUM_W'(FULL));
      end else begin
        ang <= ANG_W'(sum);
      end
    end
  end

  // sector choice and result register
  logic [3:0] sect_cnt;
  dir_t       dir_c;

  always_comb begin
    sect_cnt = '0;
    for (int k = 1; k <= 8; k++) begin
      if (ang >= ANG_W'(k * SECT - HALF)) begin
        sect_cnt = sect_cnt + 4'd1;
      end
    end
    dir_c = dir_t'({1'b0, sect_cnt[2:0]} + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= ang_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (ang_flags.in_zone) begin
        result.direction     <= DIR_CENTER;
        result.cardinal_mask <= 4'b0000;
      end else begin
        result.direction     <= dir_c;
        result.cardinal_mask <= mask_of(dir_c);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_none_no_mask: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.direction == DIR_CENTER) |-> result.cardinal_mask == 4'b0000)
    else $error("no-direction beat carries a mask");

  a_mask_weight: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.direction != DIR_CENTER) |->
      ($countones(result.cardinal_mask) == 1 || $countones(result.cardinal_mask) == 2))
    else $error("direction beat with malformed mask");

  a_cardinal_onehot: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.direction[0] |-> $onehot(result.cardinal_mask))
    else $error("cardinal direction without a single mask bit");

  a_ang_wrapped: assert property (@(posedge clk) disable iff (rst)
    ang_valid |-> ang < ANG_W'(FULL))
    else $error("angle not reduced below a full turn");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(cw_valid) && $stable(sum_valid) && $stable(ang_valid))
    else $error("pipeline moved while stalled");
`endif

endmodule
